// ===== sv/stp_pkg.sv =====
// Shared types and constants of the stepper ramp generator.
// Used by the controller, the datapath and the top level; no dependencies.
package stp_pkg;

  localparam int NUM_AXES   = 7;
  localparam int AX_W       = 3;
  localparam int DIV_W      = 48;
  localparam int SQ_STEPS   = 32;
  localparam int START_VEL  = 2560;
  localparam int MIN_LIMIT  = 10;
  localparam int IN_USER_W  = 6;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 80;

  typedef enum logic [2:0] {
    CMD_TICK, CMD_MOVE, CMD_HOME, CMD_STOP, CMD_SETPOS
  } cmd_e;

  typedef enum logic [2:0] {
    M_STOP, M_ACCEL, M_CRUISE, M_DECEL, M_BRAKE
  } motion_e;

  typedef enum logic [2:0] {
    H_IDLE, H_IN1, H_OUT1, H_IN2, H_OUT2, H_ERROR
  } homing_e;

  typedef enum logic [1:0] {
    REG_ACCEL, REG_VMAX, REG_TICK_HZ, REG_MIN_RELOAD
  } reg_e;

  typedef struct packed {
    logic latch;
    logic exec;
    logic tick;
    logic div_go;
    logic div_rel;
    logic sts_ld;
    logic decide;
    logic sqrt_go;
    logic vel_upd;
    logic rel_ld;
    logic start;
    logic home_adv;
    logic out_ld;
  } stp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic stopped;
    logic div_done;
    logic sqrt_done;
    logic need_sqrt;
    logic fin;
    logic vel_zero;
  } stp_stat_t;

endpackage

// ===== sv/stp_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on stp_pkg for the dividend width.
module stp_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [stp_pkg::DIV_W-1:0]   dividend_i,
  input  logic [31:0]                 divisor_i,
  output logic                        done_o,
  output logic [stp_pkg::DIV_W-1:0]   quot_o
);

  localparam int CW = $clog2(stp_pkg::DIV_W);

  logic [CW-1:0]              cnt_q;
  logic                       run_q;
  logic                       done_q;
  logic [31:0]                rem_q;
  logic [31:0]                dvs_q;
  logic [stp_pkg::DIV_W-1:0]  quo_q;
  logic [32:0]                rem_sh;
  logic [32:0]                diff;
  logic                       ge;

  assign rem_sh = {rem_q, quo_q[stp_pkg::DIV_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_q};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(stp_pkg::DIV_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvs_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (run_q) begin
      rem_q <= ge ? diff[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[stp_pkg::DIV_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== sv/stp_sqrt.sv =====
// Integer square root, one root bit per cycle (two radicand bits per step).
// Depends on stp_pkg for the step count.
module stp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] rad_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  localparam int CW = $clog2(stp_pkg::SQ_STEPS);

  logic [CW-1:0] cnt_q;
  logic          run_q;
  logic          done_q;
  logic [63:0]   x_q;
  logic [33:0]   rem_q;
  logic [31:0]   root_q;
  logic [35:0]   rem_sh;
  logic [35:0]   trial;
  logic          ge;

  assign rem_sh = {rem_q, x_q[63:62]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign ge     = (rem_sh >= trial);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= '0;
      run_q  <= 1'b1;
      done_q <= 1'b0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CW'(stp_pkg::SQ_STEPS - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q    <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      x_q    <= {x_q[61:0], 2'b00};
      rem_q  <= ge ? 34'(rem_sh - trial) : rem_sh[33:0];
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== sv/stp_dp.sv =====
// Datapath: axis state, configuration registers, ramp arithmetic and result register.
// Depends on stp_pkg, stp_div and stp_sqrt; sequenced by stp_ctrl.
module stp_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  stp_pkg::stp_cmd_t              cmd_i,
  output stp_pkg::stp_stat_t             stat_o,
  input  logic                           cfg_valid_i,
  input  logic [1:0]                     cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic [stp_pkg::IN_USER_W-1:0]  in_user_i,
  input  logic [stp_pkg::IN_DATA_W-1:0]  in_data_i,
  output logic [stp_pkg::OUT_DATA_W-1:0] out_data_o
);

  stp_pkg::cmd_e    cmd_q;
  logic [stp_pkg::AX_W-1:0] axis_q;
  logic [31:0]      steps_q;
  logic             sw_q;

  logic [19:0]      accel_q;
  logic [19:0]      vmax_q;
  logic [28:0]      tick_hz_q;
  logic [15:0]      min_rel_q;

  logic [31:0]      pos_q [stp_pkg::NUM_AXES];
  logic [31:0]      tgt_q [stp_pkg::NUM_AXES];
  logic [31:0]      vel_q;
  stp_pkg::motion_e mode_q;
  stp_pkg::homing_e hstage_q;
  logic [stp_pkg::AX_W-1:0] act_q;
  logic             dir_q;
  logic [31:0]      hdist_q;
  logic [stp_pkg::NUM_AXES-1:0] sbits_q;
  logic [1:0]       shift_q;
  logic [31:0]      reload_q;
  logic [63:0]      v2_q;
  logic [31:0]      sts_q;
  logic [31:0]      mag_q;
  logic             acc_q;
  logic             fin_q;
  logic             pend_q;
  logic [31:0]      sm_st_q;
  logic [stp_pkg::OUT_DATA_W-1:0] out_q;

  logic [31:0]      cur_pos;
  logic [31:0]      cur_tgt;
  logic [31:0]      rem;
  logic [31:0]      mag;
  logic [63:0]      two_a;
  logic             sq_gt;
  logic [31:0]      vm;
  logic [31:0]      off;
  logic             sw_hit;
  logic             ax_ok;
  logic             idle_stop;
  logic [63:0]      sq_w;
  logic [stp_pkg::DIV_W-1:0] div_a;
  logic [31:0]      div_b;
  logic [stp_pkg::DIV_W-1:0] quot;
  logic [31:0]      quot_sat;
  logic [31:0]      rel_val;
  logic [31:0]      rel_fl;
  logic [63:0]      rad;
  logic [31:0]      root;
  logic             div_done;
  logic             sqrt_done;
  logic             limits_ok;

  assign cur_pos  = pos_q[act_q];
  assign cur_tgt  = tgt_q[act_q];
  assign rem      = cur_tgt - cur_pos;
  assign mag      = rem[31] ? (32'd0 - rem) : rem;
  assign two_a    = {27'd0, accel_q, 17'd0};
  assign sq_gt    = (v2_q > two_a);
  assign vm       = {4'd0, vmax_q, 8'd0} >> shift_q;
  assign off      = sts_q[31] ? 32'h7FFF_FFFF : sts_q;
  assign ax_ok    = ({1'b0, axis_q} < (stp_pkg::AX_W + 1)'(stp_pkg::NUM_AXES));
  assign idle_stop = (mode_q == stp_pkg::M_STOP);
  assign limits_ok = (vmax_q >= 20'(stp_pkg::MIN_LIMIT)) && (accel_q >= 20'(stp_pkg::MIN_LIMIT));
  assign sq_w     = vel_q * vel_q;

  always_comb begin
    sw_hit = 1'b0;
    if ((hstage_q == stp_pkg::H_IN1 || hstage_q == stp_pkg::H_IN2) && sw_q) sw_hit = 1'b1;
    if ((hstage_q == stp_pkg::H_OUT1 || hstage_q == stp_pkg::H_OUT2) && !sw_q) sw_hit = 1'b1;
  end

  // Shared divider: stop distance first, reload second.
  assign div_a = cmd_i.div_rel ? {12'd0, tick_hz_q, 7'd0} : {1'b0, v2_q[63:17]};
  assign div_b = cmd_i.div_rel ? vel_q : {12'd0, accel_q};
  assign quot_sat = (|quot[stp_pkg::DIV_W-1:32]) ? 32'hFFFF_FFFF : quot[31:0];
  assign rel_val  = (vel_q == 32'd0) ? 32'hFFFF_FFFF : quot_sat;
  assign rel_fl   = (rel_val < {16'd0, min_rel_q}) ? {16'd0, min_rel_q} : rel_val;

  assign rad = (mode_q == stp_pkg::M_ACCEL) ? (v2_q + two_a) : (v2_q - two_a);

  stp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_go),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  stp_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.sqrt_go),
    .rad_i   (rad),
    .done_o  (sqrt_done),
    .root_o  (root)
  );

  // Request fields are captured once and held for the whole command.
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= stp_pkg::cmd_e'(in_user_i[2:0]);
      axis_q  <= in_user_i[5:3];
      steps_q <= in_data_i[31:0];
      sw_q    <= in_data_i[32];
    end
    if (cmd_i.tick) v2_q <= sq_w;
    if (cmd_i.sts_ld) begin
      mag_q <= mag;
      if (accel_q == 20'd0) sts_q <= (vel_q != 32'd0) ? 32'hFFFF_FFFF : 32'd0;
      else sts_q <= quot_sat;
    end
    if (cmd_i.out_ld) begin
      out_q <= {1'b0, pos_q[act_q], hstage_q, mode_q, reload_q, dir_q,
                7'(sbits_q), acc_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_q   <= '0;
      vmax_q    <= '0;
      tick_hz_q <= 29'd9821428;
      min_rel_q <= 16'd42;
      for (int i = 0; i < stp_pkg::NUM_AXES; i++) begin
        pos_q[i] <= '0;
        tgt_q[i] <= '0;
      end
      vel_q    <= '0;
      mode_q   <= stp_pkg::M_STOP;
      hstage_q <= stp_pkg::H_IDLE;
      act_q    <= '0;
      dir_q    <= 1'b0;
      hdist_q  <= '0;
      sbits_q  <= '0;
      shift_q  <= '0;
      reload_q <= '0;
      acc_q    <= 1'b0;
      fin_q    <= 1'b0;
      pend_q   <= 1'b0;
      sm_st_q  <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (stp_pkg::reg_e'(cfg_index_i))
          stp_pkg::REG_ACCEL:      accel_q   <= cfg_data_i[19:0];
          stp_pkg::REG_VMAX:       vmax_q    <= cfg_data_i[19:0];
          stp_pkg::REG_TICK_HZ:    tick_hz_q <= cfg_data_i[28:0];
          stp_pkg::REG_MIN_RELOAD: min_rel_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      if (cmd_i.latch) begin
        acc_q  <= 1'b0;
        fin_q  <= 1'b0;
        pend_q <= 1'b0;
      end

      if (cmd_i.exec) begin
        case (cmd_q)
          stp_pkg::CMD_MOVE: begin
            if (ax_ok && idle_stop && hstage_q == stp_pkg::H_IDLE && limits_ok) begin
              act_q   <= axis_q;
              sm_st_q <= steps_q;
              pend_q  <= 1'b1;
              acc_q   <= 1'b1;
            end
          end
          stp_pkg::CMD_HOME: begin
            if (ax_ok && idle_stop &&
                (hstage_q == stp_pkg::H_IDLE || hstage_q == stp_pkg::H_ERROR)) begin
              hstage_q <= stp_pkg::H_IN1;
              hdist_q  <= steps_q;
              act_q    <= axis_q;
              sm_st_q  <= steps_q;
              pend_q   <= 1'b1;
              acc_q    <= 1'b1;
            end
          end
          stp_pkg::CMD_STOP: begin
            if (mode_q == stp_pkg::M_ACCEL || mode_q == stp_pkg::M_CRUISE ||
                mode_q == stp_pkg::M_DECEL) begin
              mode_q <= stp_pkg::M_BRAKE;
              acc_q  <= 1'b1;
            end
          end
          stp_pkg::CMD_SETPOS: begin
            if (ax_ok) begin
              for (int i = 0; i < stp_pkg::NUM_AXES; i++) begin
                if (axis_q == stp_pkg::AX_W'(i)) begin
                  pos_q[i] <= steps_q;
                  tgt_q[i] <= steps_q;
                end
              end
              acc_q <= 1'b1;
            end
          end
          default: ;
        endcase
      end

      // Half step: toggle the step line and advance the position.
      if (cmd_i.tick) begin
        acc_q <= 1'b1;
        for (int i = 0; i < stp_pkg::NUM_AXES; i++) begin
          if (act_q == stp_pkg::AX_W'(i)) begin
            sbits_q[i] <= ~sbits_q[i];
            pos_q[i]   <= pos_q[i] + (dir_q ? 32'hFFFF_FFFF : 32'd1);
          end
        end
      end

      if (cmd_i.decide && mode_q != stp_pkg::M_DECEL) begin
        if (sw_hit) begin
          for (int i = 0; i < stp_pkg::NUM_AXES; i++) begin
            if (act_q == stp_pkg::AX_W'(i)) tgt_q[i] <= dir_q ? (cur_pos - off) : (cur_pos + off);
          end
        end
        if (sw_hit || mag_q <= sts_q) mode_q <= stp_pkg::M_DECEL;
      end

      if (cmd_i.vel_upd) begin
        case (mode_q)
          stp_pkg::M_ACCEL: begin
            if (root >= vm) begin
              vel_q  <= vm;
              mode_q <= stp_pkg::M_CRUISE;
            end else begin
              vel_q <= root;
            end
          end
          stp_pkg::M_DECEL: begin
            if ((sq_gt ? root : vel_q) == 32'd0 || mag_q == 32'd0) begin
              vel_q  <= '0;
              mode_q <= stp_pkg::M_STOP;
              fin_q  <= 1'b1;
            end else if (sq_gt) begin
              vel_q <= root;
            end
          end
          stp_pkg::M_BRAKE: begin
            if (sq_gt) begin
              vel_q <= root;
            end else begin
              vel_q  <= '0;
              mode_q <= stp_pkg::M_STOP;
              fin_q  <= 1'b1;
              for (int i = 0; i < stp_pkg::NUM_AXES; i++) begin
                if (act_q == stp_pkg::AX_W'(i)) tgt_q[i] <= pos_q[i];
              end
            end
          end
          default: ;
        endcase
      end

      if (cmd_i.rel_ld) reload_q <= rel_fl;

      // Launch a pending move on the active axis.
      if (cmd_i.start && pend_q) begin
        pend_q <= 1'b0;
        vel_q  <= 32'(stp_pkg::START_VEL);
        mode_q <= stp_pkg::M_ACCEL;
        dir_q  <= sm_st_q[31];
        for (int i = 0; i < stp_pkg::NUM_AXES; i++) begin
          if (act_q == stp_pkg::AX_W'(i)) tgt_q[i] <= pos_q[i] + sm_st_q;
        end
      end

      if (cmd_i.home_adv && idle_stop) begin
        case (hstage_q)
          stp_pkg::H_IDLE, stp_pkg::H_ERROR: ;
          stp_pkg::H_IN1: begin
            hstage_q <= stp_pkg::H_OUT1;
            sm_st_q  <= 32'd0 - hdist_q;
            pend_q   <= 1'b1;
          end
          stp_pkg::H_OUT1: begin
            hstage_q <= stp_pkg::H_IN2;
            shift_q  <= 2'd1;
            sm_st_q  <= hdist_q;
            pend_q   <= 1'b1;
          end
          stp_pkg::H_IN2: begin
            hstage_q <= stp_pkg::H_OUT2;
            shift_q  <= 2'd2;
            sm_st_q  <= 32'd0 - hdist_q;
            pend_q   <= 1'b1;
          end
          default: begin
            hstage_q <= stp_pkg::H_IDLE;
            shift_q  <= 2'd0;
            for (int i = 0; i < stp_pkg::NUM_AXES; i++) begin
              if (act_q == stp_pkg::AX_W'(i)) begin
                pos_q[i] <= '0;
                tgt_q[i] <= '0;
              end
            end
          end
        endcase
      end
    end
  end

  assign stat_o.is_tick   = (cmd_q == stp_pkg::CMD_TICK);
  assign stat_o.stopped   = idle_stop;
  assign stat_o.div_done  = div_done;
  assign stat_o.sqrt_done = sqrt_done;
  assign stat_o.need_sqrt = (mode_q == stp_pkg::M_ACCEL) ||
                            ((mode_q == stp_pkg::M_DECEL || mode_q == stp_pkg::M_BRAKE) && sq_gt);
  assign stat_o.fin       = fin_q;
  assign stat_o.vel_zero  = (vel_q == 32'd0);
  assign out_data_o       = out_q;

endmodule

// ===== sv/stp_ctrl.sv =====
// Controller: sequences one request through the datapath and owns the handshakes.
// Depends on stp_pkg for the command and status structs.
module stp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output stp_pkg::stp_cmd_t  cmd_o,
  input  stp_pkg::stp_stat_t stat_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_CMD, S_TDIV1, S_TDIV1W, S_TDEC, S_TSQ, S_TSQW, S_TVEL,
    S_TREL, S_TRELW, S_ST1, S_HOME, S_ST2, S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   can_load;

  assign can_load = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_CMD;
        end
      end
      S_CMD: begin
        if (!stat_i.is_tick) begin
          cmd_o.exec = 1'b1;
          state_d    = S_ST1;
        end else if (stat_i.stopped) begin
          state_d = S_ST1;
        end else begin
          cmd_o.tick = 1'b1;
          state_d    = S_TDIV1;
        end
      end
      S_TDIV1: begin
        cmd_o.div_go = 1'b1;
        state_d      = S_TDIV1W;
      end
      S_TDIV1W: begin
        if (stat_i.div_done) begin
          cmd_o.sts_ld = 1'b1;
          state_d      = S_TDEC;
        end
      end
      S_TDEC: begin
        cmd_o.decide = 1'b1;
        state_d      = S_TSQ;
      end
      S_TSQ: begin
        if (stat_i.need_sqrt) begin
          cmd_o.sqrt_go = 1'b1;
          state_d       = S_TSQW;
        end else begin
          state_d = S_TVEL;
        end
      end
      S_TSQW: begin
        if (stat_i.sqrt_done) state_d = S_TVEL;
      end
      S_TVEL: begin
        cmd_o.vel_upd = 1'b1;
        state_d       = S_TREL;
      end
      S_TREL: begin
        if (stat_i.fin) begin
          state_d = S_ST1;
        end else if (stat_i.vel_zero) begin
          cmd_o.rel_ld = 1'b1;
          state_d      = S_ST1;
        end else begin
          cmd_o.div_go  = 1'b1;
          cmd_o.div_rel = 1'b1;
          state_d       = S_TRELW;
        end
      end
      S_TRELW: begin
        cmd_o.div_rel = 1'b1;
        if (stat_i.div_done) begin
          cmd_o.rel_ld = 1'b1;
          state_d      = S_ST1;
        end
      end
      S_ST1: begin
        cmd_o.start = 1'b1;
        state_d     = S_HOME;
      end
      S_HOME: begin
        cmd_o.home_adv = 1'b1;
        state_d        = S_ST2;
      end
      S_ST2: begin
        cmd_o.start = 1'b1;
        state_d     = S_DONE;
      end
      S_DONE: begin
        if (can_load) begin
          cmd_o.out_ld = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_ld) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/stepper_trapezoid_ramp_homing.sv =====
// Top level of the multi-axis stepper ramp generator with reference-switch homing.
// Depends on stp_pkg, stp_ctrl and stp_dp (which holds stp_div and stp_sqrt).
//
// One request in gives one result out. Requests carry a command (tick, move, home,
// stop, set position), an axis, a step count and the reference switch level. A tick
// is one half step of the active axis: it toggles that axis's step line, moves its
// position, updates the speed along the trapezoidal profile (v' = sqrt(v^2 +/- 2a),
// unsigned 24.8 fixed point) and computes the next timer reload tick_hz/(2v), floored
// at min_reload. Homing runs four moves (in, out, in at half speed, out at quarter
// speed) and then zeroes the axis position. Non-tick commands and ticks while stopped
// skip the divider and the square root unit; a moving tick waits on the shared
// one-bit-per-cycle divider (used for stop distance and reload) and, when needed, on
// the square root unit. One request is in flight at a time; the result sits in an
// output register, so the next request is taken as soon as the result is loaded.
// Configuration writes are always ready and belong in idle periods only.
module stepper_trapezoid_ramp_homing (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request channel
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // steps[31:0], ref_switch[32], zero fill
  input  logic [5:0]  s_axis_tuser,  // cmd[2:0], axis[5:3]
  // Result channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,  // accepted[0], step_levels[7:1], dir_level[8],
                                     // reload[40:9], motion_state[43:41],
                                     // homing_state[46:44], position[78:47], zero fill
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  stp_pkg::stp_cmd_t  cmd;
  stp_pkg::stp_stat_t stat;

  // Register writes never stall.
  assign cfg_ready_o = 1'b1;

  stp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  stp_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_user_i   (s_axis_tuser),
    .in_data_i   (s_axis_tdata),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== tb/stepper_ramp_checker.sv =====
// Checker for the stepper ramp generator: watches the request, result and
// configuration channels, predicts each result and compares. Depends on stp_pkg.
`timescale 1ns / 100ps
module stepper_ramp_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [39:0] req_data_i,
  input  logic [5:0]  req_user_i,
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [79:0] res_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          pending_o,
  output int          errors_o
);

  typedef struct packed {
    logic [31:0]      position;
    stp_pkg::homing_e homing;
    stp_pkg::motion_e motion;
    logic [31:0]      reload;
    logic             dir;
    logic [6:0]       steps;
    logic             accepted;
  } ramp_result_t;

  logic [31:0] p_accel, p_vmax, p_tick_hz, p_min_reload;
  logic [31:0] p_pos [stp_pkg::NUM_AXES];
  logic [31:0] p_tgt [stp_pkg::NUM_AXES];
  logic [31:0] p_vel, p_home_dist, p_reload;
  stp_pkg::motion_e p_motion;
  stp_pkg::homing_e p_homing;
  logic [2:0]  p_axis;
  logic        p_dir;
  logic [6:0]  p_step_bits;
  logic [1:0]  p_shift;
  ramp_result_t expected_results[$];
  int errors;
  int pending;

  assign pending_o = pending;
  assign errors_o  = errors;

  function automatic logic [63:0] int_sqrt(logic [63:0] x);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] brake_distance();
    logic [63:0] q;
    if (p_accel == 0) return (p_vel != 0) ? 32'hFFFF_FFFF : 32'd0;
    q = (64'(p_vel) * 64'(p_vel)) / (64'(p_accel) * 64'd131072);
    return (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
  endfunction

  task automatic launch(logic [31:0] stp, logic [2:0] ax);
    p_axis = ax;
    p_tgt[ax] = p_pos[ax] + stp;
    p_vel = 32'(stp_pkg::START_VEL);
    p_motion = stp_pkg::M_ACCEL;
    p_dir = stp[31];
  endtask

  function automatic void decel_on_switch(logic [31:0] brk_dist);
    logic [31:0] off;
    off = (brk_dist > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : brk_dist;
    p_motion = stp_pkg::M_DECEL;
    p_tgt[p_axis] = p_dir ? p_pos[p_axis] - off : p_pos[p_axis] + off;
  endfunction

  function automatic logic half_step(logic sw);
    logic [2:0]  ax;
    logic [31:0] rem, mag, brk_dist, vlim;
    logic [63:0] v2, two_a, q;
    ax = p_axis;
    if (p_motion == stp_pkg::M_STOP) return 1'b0;
    p_step_bits[ax] = ~p_step_bits[ax];
    p_pos[ax] = p_pos[ax] + (p_dir ? 32'hFFFF_FFFF : 32'd1);
    rem = p_tgt[ax] - p_pos[ax];
    mag = rem[31] ? -rem : rem;
    brk_dist = brake_distance();
    if (p_motion != stp_pkg::M_DECEL) begin
      if ((p_homing == stp_pkg::H_IN1 || p_homing == stp_pkg::H_IN2) && sw)
        decel_on_switch(brk_dist);
      else if ((p_homing == stp_pkg::H_OUT1 || p_homing == stp_pkg::H_OUT2) && !sw)
        decel_on_switch(brk_dist);
      if (mag <= brk_dist) p_motion = stp_pkg::M_DECEL;
    end
    v2 = 64'(p_vel) * 64'(p_vel);
    two_a = 64'(p_accel) * 64'd131072;
    case (p_motion)
      stp_pkg::M_ACCEL: begin
        vlim = (p_vmax << 8) >> p_shift;
        p_vel = 32'(int_sqrt(v2 + two_a));
        if (p_vel >= vlim) begin
          p_vel = vlim;
          p_motion = stp_pkg::M_CRUISE;
        end
      end
      stp_pkg::M_DECEL: begin
        if (v2 > two_a) p_vel = 32'(int_sqrt(v2 - two_a));
        if (p_vel == 0 || mag == 0) begin
          p_vel = '0;
          p_motion = stp_pkg::M_STOP;
          return 1'b1;
        end
      end
      stp_pkg::M_BRAKE: begin
        if (v2 > two_a) p_vel = 32'(int_sqrt(v2 - two_a));
        else begin
          p_vel = '0;
          p_tgt[ax] = p_pos[ax];
          p_motion = stp_pkg::M_STOP;
          return 1'b1;
        end
      end
      default: ;
    endcase
    if (p_vel == 0) q = 64'hFFFF_FFFF;
    else begin
      q = (64'(p_tick_hz) * 64'd128) / 64'(p_vel);
      if (q > 64'hFFFF_FFFF) q = 64'hFFFF_FFFF;
    end
    if (q < 64'(p_min_reload)) q = 64'(p_min_reload);
    p_reload = q[31:0];
    return 1'b1;
  endfunction

  task automatic step_homing();
    if (p_homing == stp_pkg::H_IDLE || p_homing == stp_pkg::H_ERROR ||
        p_motion != stp_pkg::M_STOP) return;
    case (p_homing)
      stp_pkg::H_IN1: begin
        p_homing = stp_pkg::H_OUT1;
        launch(-p_home_dist, p_axis);
      end
      stp_pkg::H_OUT1: begin
        p_homing = stp_pkg::H_IN2;
        p_shift = 2'd1;
        launch(p_home_dist, p_axis);
      end
      stp_pkg::H_IN2: begin
        p_homing = stp_pkg::H_OUT2;
        p_shift = 2'd2;
        launch(-p_home_dist, p_axis);
      end
      default: begin
        p_homing = stp_pkg::H_IDLE;
        p_shift = 2'd0;
        p_pos[p_axis] = '0;
        p_tgt[p_axis] = '0;
      end
    endcase
  endtask

  task automatic predict_request(logic [2:0] cmd, logic [2:0] ax, logic [31:0] stp,
                                 logic sw);
    logic ok, acc;
    ramp_result_t r;
    ok = (ax < 3'(stp_pkg::NUM_AXES));
    acc = 1'b0;
    case (cmd)
      stp_pkg::CMD_TICK: acc = half_step(sw);
      stp_pkg::CMD_MOVE:
        if (ok && p_motion == stp_pkg::M_STOP && p_homing == stp_pkg::H_IDLE &&
            p_vmax >= 32'(stp_pkg::MIN_LIMIT) && p_accel >= 32'(stp_pkg::MIN_LIMIT)) begin
          launch(stp, ax);
          acc = 1'b1;
        end
      stp_pkg::CMD_HOME:
        if (ok && p_motion == stp_pkg::M_STOP &&
            (p_homing == stp_pkg::H_IDLE || p_homing == stp_pkg::H_ERROR)) begin
          p_homing = stp_pkg::H_IN1;
          p_home_dist = stp;
          launch(stp, ax);
          acc = 1'b1;
        end
      stp_pkg::CMD_STOP:
        if (p_motion == stp_pkg::M_ACCEL || p_motion == stp_pkg::M_CRUISE ||
            p_motion == stp_pkg::M_DECEL) begin
          p_motion = stp_pkg::M_BRAKE;
          acc = 1'b1;
        end
      stp_pkg::CMD_SETPOS:
        if (ok) begin
          p_pos[ax] = stp;
          p_tgt[ax] = stp;
          acc = 1'b1;
        end
      default: ;
    endcase
    step_homing();
    r.accepted = acc;
    r.steps    = p_step_bits;
    r.dir      = p_dir;
    r.reload   = p_reload;
    r.motion   = p_motion;
    r.homing   = p_homing;
    r.position = p_pos[p_axis];
    expected_results.push_back(r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ramp_result_t want, got;
    if (!rst_ni) begin
      p_accel = '0; p_vmax = '0; p_tick_hz = 32'd9821428; p_min_reload = 32'd42;
      for (int i = 0; i < stp_pkg::NUM_AXES; i++) begin
        p_pos[i] = '0;
        p_tgt[i] = '0;
      end
      p_vel = '0; p_motion = stp_pkg::M_STOP; p_homing = stp_pkg::H_IDLE;
      p_axis = '0; p_dir = 1'b0;
      p_home_dist = '0; p_step_bits = '0; p_shift = '0; p_reload = '0;
      expected_results.delete();
      pending = 0;
      errors = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (stp_pkg::reg_e'(cfg_index_i))
          stp_pkg::REG_ACCEL:      p_accel = 32'(cfg_data_i[19:0]);
          stp_pkg::REG_VMAX:       p_vmax = 32'(cfg_data_i[19:0]);
          stp_pkg::REG_TICK_HZ:    p_tick_hz = 32'(cfg_data_i[28:0]);
          stp_pkg::REG_MIN_RELOAD: p_min_reload = 32'(cfg_data_i[15:0]);
          default: ;
        endcase
      end
      // compare first: a result cannot belong to a request taken at the same edge
      if (res_valid_i && res_ready_i) begin
        got = res_data_i[78:0];
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: acc %b/%b steps %h/%h dir %b/%b reload %h/%h",
                        " mot %0d/%0d hom %0d/%0d pos %h/%h"},
                       want.accepted, got.accepted, want.steps, got.steps, want.dir, got.dir,
                       want.reload, got.reload, want.motion, got.motion, want.homing,
                       got.homing, want.position, got.position);
          end
        end
      end
      if (req_valid_i && req_ready_i)
        predict_request(req_user_i[2:0], req_user_i[5:3], req_data_i[31:0], req_data_i[32]);
      pending = expected_results.size();
    end
  end

endmodule

// ===== tb/tb_stepper_trapezoid_ramp_homing.sv =====
// Testbench top of the stepper ramp generator: clock, reset, requests,
// configuration phases and verdict. Depends on stp_pkg and stepper_ramp_checker.
`timescale 1ns / 100ps
module tb_stepper_trapezoid_ramp_homing;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic [5:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;
  int          pending, errors;
  int          send_idle_pct = 31, recv_idle_pct = 79;
  logic        hold_toggle = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_cnt = 0;
  longint      cycles = 0;

  always #4 clk_i = ~clk_i;

  stepper_trapezoid_ramp_homing dut (.*);

  stepper_ramp_checker checker_i (
    .clk_i, .rst_ni,
    .req_valid_i(s_axis_tvalid), .req_ready_i(s_axis_tready),
    .req_data_i(s_axis_tdata), .req_user_i(s_axis_tuser),
    .res_valid_i(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_data_i(m_axis_tdata),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .pending_o(pending), .errors_o(errors)
  );

  // Receiver: random stall, or a long hold-off when one is asked for.
  always @(negedge clk_i) begin
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_cnt <= 300;
      m_axis_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: a stuck handshake anywhere ends the run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 2_000_000) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic write_reg(stp_pkg::reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send(stp_pkg::cmd_e cmd, logic [2:0] ax, logic [31:0] stp, logic sw);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= {ax, cmd};
    s_axis_tdata  <= {7'd0, sw, stp};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
  endtask

  // Wait until every result has come, plus some margin.
  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_profile(logic [31:0] a, logic [31:0] v, logic [31:0] hz,
                             logic [31:0] mr);
    drain();
    write_reg(stp_pkg::REG_ACCEL, a);
    write_reg(stp_pkg::REG_VMAX, v);
    write_reg(stp_pkg::REG_TICK_HZ, hz);
    write_reg(stp_pkg::REG_MIN_RELOAD, mr);
  endtask

  // A move of modest length, then between 5 and 50 ticks, with the odd stop command.
  task automatic random_move(ref int sent);
    logic [31:0] stp;
    int n;
    stp = $urandom_range(1, 40);
    if ($urandom_range(1)) stp = -stp;
    send(stp_pkg::CMD_MOVE, 3'($urandom_range(stp_pkg::NUM_AXES - 1)), stp,
         1'($urandom_range(1)));
    n = $urandom_range(5, 50);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0)
        send(stp_pkg::CMD_STOP, 3'($urandom), $urandom, 1'($urandom_range(1)));
      else send(stp_pkg::CMD_TICK, 3'($urandom), $urandom, 1'($urandom_range(1)));
    end
    sent += n + 1;
  endtask

  // Home sequence: ticks with a switch that toggles now and then.
  task automatic random_home(ref int sent);
    logic sw;
    logic [31:0] hd;
    int n;
    sw = 1'b0;
    hd = $urandom_range(1, 30);
    if ($urandom_range(1)) hd = -hd;
    send(stp_pkg::CMD_HOME, 3'($urandom_range(stp_pkg::NUM_AXES - 1)), hd, 1'b0);
    n = $urandom_range(20, 80);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(5) == 0) sw = ~sw;
      send(stp_pkg::CMD_TICK, 3'($urandom), $urandom, sw);
    end
    sent += n + 1;
  endtask

  task automatic random_phase(int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(9))
        0: begin
          send(stp_pkg::CMD_SETPOS, 3'($urandom), $urandom, 1'($urandom_range(1)));
          sent++;
        end
        1: begin
          send(stp_pkg::cmd_e'($urandom_range(5, 7)), 3'($urandom), $urandom,
               1'($urandom_range(1)));
          sent++;
        end
        2, 3: random_home(sent);
        default: random_move(sent);
      endcase
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: registers at reset, rejected moves, bad axis, odd codes.
    send(stp_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send(stp_pkg::CMD_MOVE, 3'd0, 32'd10, 1'b0);
    send(stp_pkg::CMD_STOP, 3'd0, 32'd0, 1'b0);
    send(stp_pkg::CMD_SETPOS, 3'd7, 32'h7FFF_FFFF, 1'b1);
    send(stp_pkg::CMD_SETPOS, 3'd6, 32'h8000_0000, 1'b0);
    send(stp_pkg::CMD_SETPOS, 3'd6, 32'hFFFF_FFFF, 1'b1);
    send(stp_pkg::cmd_e'(3'd7), 3'd7, 32'hFFFF_FFFF, 1'b1);
    send(stp_pkg::CMD_HOME, 3'd7, 32'd5, 1'b0);
    set_profile(20000, 1000, 9821428, 42);
    send(stp_pkg::CMD_MOVE, 3'd7, 32'd5, 1'b0);
    send(stp_pkg::CMD_MOVE, 3'd2, 32'd6, 1'b0);
    for (int i = 0; i < 6; i++) send(stp_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send(stp_pkg::CMD_MOVE, 3'd1, -32'd3, 1'b0);
    send(stp_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send(stp_pkg::CMD_STOP, 3'd0, 32'd0, 1'b0);
    for (int i = 0; i < 4; i++) send(stp_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    // slowest legal profile, and reload extremes
    set_profile(10, 10, 1, 1);
    send(stp_pkg::CMD_MOVE, 3'd0, 32'h7FFF_FFFF, 1'b1);
    send(stp_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);
    send(stp_pkg::CMD_STOP, 3'd0, 32'd0, 1'b0);
    for (int i = 0; i < 3; i++) send(stp_pkg::CMD_TICK, 3'd0, 32'd0, 1'b0);

    // Random phases over several register settings, idling as ordered.
    send_idle_pct = 31; recv_idle_pct = 79;
    set_profile(1_000_000, 1_000_000, 400_000_000, 65535);
    random_phase(160);
    send_idle_pct = 79; recv_idle_pct = 31;
    set_profile($urandom_range(10, 5000), $urandom_range(10, 3000),
                $urandom_range(1, 400_000_000), $urandom_range(1, 65535));
    random_phase(160);
    set_profile(0, 9, 9821428, 42);
    random_phase(25);
    send_idle_pct = 0; recv_idle_pct = 0;
    set_profile(5000, 2000, 9821428, 42);
    // Long receiver hold-off with the sender still offering.
    hold_toggle = ~hold_toggle;
    random_phase(55);
    drain();
    random_phase(110);

    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
